// File: src/cst_pkg.sv
// types and constants shared by the client session table
// no dependencies
package cst_pkg;

  // widest slot index the table parameter can need (256 entries)
  localparam int unsigned MAX_IDX_W = 8;

  localparam logic [1:0] OP_CHECK    = 2'd0;
  localparam logic [1:0] OP_ISSUE    = 2'd1;
  localparam logic [1:0] OP_VALIDATE = 2'd2;

  localparam logic [2:0] OUT_NONE     = 3'd0;
  localparam logic [2:0] OUT_ALREADY  = 3'd1;
  localparam logic [2:0] OUT_DIRECT   = 3'd2;
  localparam logic [2:0] OUT_CODE_OK  = 3'd3;
  localparam logic [2:0] OUT_MISMATCH = 3'd4;

  // 27^6, six base-27 symbols
  localparam logic [28:0] CODE_LIMIT = 29'd387420489;
  localparam logic [31:0] TTL_RESET  = 32'd1800000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] client_ip;
    logic [31:0] now_ms;
    logic [28:0] new_code;
    logic [28:0] provided_code;
    logic        has_provided_code;
  } cst_in_t;

  typedef struct packed {
    logic        entry_found;
    logic        validated;
    logic [28:0] code;
    logic        code_present;
    logic [2:0]  outcome;
    logic [4:0]  slot;
  } cst_out_t;

  typedef struct packed {
    logic                 hit;
    logic [MAX_IDX_W-1:0] hit_idx;
    logic                 free;
    logic [MAX_IDX_W-1:0] free_idx;
  } cst_lookup_t;

endpackage

// File: src/cst_match.sv
// parallel key and age compare over all entries, with first-match encoders
// depends on cst_pkg
module cst_match #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic [31:0]          client_ip,
  input  logic [31:0]          now_ms,
  input  logic [31:0]          ttl_ms,
  input  logic [31:0]          key   [TABLE_ENTRIES],
  input  logic [31:0]          seen  [TABLE_ENTRIES],
  output cst_pkg::cst_lookup_t lookup
);
  import cst_pkg::*;

  logic [TABLE_ENTRIES-1:0] live;
  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] avail;
  logic [31:0]              age [TABLE_ENTRIES];

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      age[i]   = now_ms - seen[i];
      live[i]  = age[i] < ttl_ms;
      match[i] = (key[i] == client_ip) && live[i];
      avail[i] = (key[i] == 32'd0) || !live[i];
    end
  end

  // scan downwards so the lowest index wins
  always_comb begin
    lookup = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = MAX_IDX_W'(i);
      end
      if (avail[i]) begin
        lookup.free     = 1'b1;
        lookup.free_idx = MAX_IDX_W'(i);
      end
    end
  end

endmodule

// File: src/client_session_table_ttl_core.sv
// top level of the client session table: input register, entry store, result register
// depends on cst_pkg and cst_match
//
// Each request beat is registered at the edge where start is high, is looked up and
// applied to the entry store in the following cycle; its result is registered
// into out_data at the end of that cycle, with out_valid high for exactly one cycle.
// busy stays low, so a request can be started in every cycle: the whole lookup
// (parallel key and age compare over all entries, first-match encode) and update
// fit between the input register and the result register, and each request sees the
// table as left by the one before. The receiver cannot stall and must take each
// result in the cycle it is shown. The lifetime register is written through the cfg
// channel, which is always ready; write it only while no request is in flight.
module client_session_table_ttl_core #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cst_pkg::cst_in_t in_data,
  output logic             out_valid,
  output cst_pkg::cst_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);
  import cst_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic        in_vld_r;
  cst_in_t     in_r;
  logic [31:0] ttl_r;
  logic        out_valid_r;
  cst_out_t    out_r, out_nxt;

  logic [31:0] key_r     [TABLE_ENTRIES];
  logic [31:0] seen_r    [TABLE_ENTRIES];
  logic        vflag_r   [TABLE_ENTRIES];
  logic        hascode_r [TABLE_ENTRIES];
  logic [28:0] code_r    [TABLE_ENTRIES];

  cst_lookup_t lk;
  logic        hit;
  logic [IDX_W-1:0] tidx;
  logic [MAX_IDX_W-1:0] slot_w;
  logic        cur_flag, cur_hc, eff_flag, eff_hc;
  logic [28:0] cur_code, reduced_code;
  logic        seen_we, entry_we, code_we;
  logic        flag_nxt, hc_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  cst_match #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_match (
    .client_ip (in_r.client_ip),
    .now_ms    (in_r.now_ms),
    .ttl_ms    (ttl_r),
    .key       (key_r),
    .seen      (seen_r),
    .lookup    (lk)
  );

  always_comb begin
    hit = lk.hit && (in_r.client_ip != 32'd0);
    if (hit) begin
      tidx = lk.hit_idx[IDX_W-1:0];
    end else if (lk.free) begin
      tidx = lk.free_idx[IDX_W-1:0];
    end else begin
      tidx = '0;
    end
    slot_w   = MAX_IDX_W'(tidx);
    cur_flag = vflag_r[tidx];
    cur_hc   = hascode_r[tidx];
    cur_code = code_r[tidx];
    // a freshly allocated entry starts unvalidated with no code
    eff_flag = hit && cur_flag;
    eff_hc   = hit && cur_hc;
    reduced_code = (in_r.new_code >= CODE_LIMIT) ? (in_r.new_code - CODE_LIMIT)
                                                 : in_r.new_code;

    out_nxt  = '0;
    seen_we  = 1'b0;
    entry_we = 1'b0;
    code_we  = 1'b0;
    flag_nxt = eff_flag;
    hc_nxt   = eff_hc;

    if (in_vld_r && (in_r.client_ip != 32'd0)) begin
      case (in_r.operation)
        OP_CHECK: begin
          if (hit) begin
            seen_we           = 1'b1;
            out_nxt.entry_found = 1'b1;
            out_nxt.validated = cur_flag;
            out_nxt.slot      = slot_w[4:0];
          end
        end
        OP_ISSUE: begin
          entry_we = 1'b1;
          seen_we  = 1'b1;
          code_we  = !eff_hc;
          hc_nxt   = 1'b1;
          out_nxt.entry_found  = hit;
          out_nxt.validated    = eff_flag;
          out_nxt.code         = eff_hc ? cur_code : reduced_code;
          out_nxt.code_present = 1'b1;
          out_nxt.slot         = slot_w[4:0];
        end
        OP_VALIDATE: begin
          entry_we = 1'b1;
          seen_we  = 1'b1;
          flag_nxt = 1'b1;
          hc_nxt   = eff_flag ? eff_hc : 1'b0;
          if (eff_flag) begin
            out_nxt.outcome = OUT_ALREADY;
          end else if (!in_r.has_provided_code) begin
            out_nxt.outcome = OUT_DIRECT;
          end else if (eff_hc && (cur_code == in_r.provided_code)) begin
            out_nxt.outcome = OUT_CODE_OK;
          end else begin
            out_nxt.outcome = OUT_MISMATCH;
          end
          out_nxt.entry_found = hit;
          out_nxt.validated   = 1'b1;
          out_nxt.slot        = slot_w[4:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ttl_r       <= TTL_RESET;
    end else begin
      in_vld_r    <= start && !busy;
      out_valid_r <= in_vld_r;
      if (cfg_valid && cfg_ready) begin
        ttl_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        key_r[i]     <= '0;
        seen_r[i]    <= '0;
        vflag_r[i]   <= 1'b0;
        hascode_r[i] <= 1'b0;
      end
    end else begin
      if (seen_we) begin
        seen_r[tidx] <= in_r.now_ms;
      end
      if (entry_we) begin
        key_r[tidx]     <= in_r.client_ip;
        vflag_r[tidx]   <= flag_nxt;
        hascode_r[tidx] <= hc_nxt;
      end
    end
  end

  // code store is only read behind its has-code bit
  always_ff @(posedge clk) begin
    if (code_we) begin
      code_r[tidx] <= reduced_code;
    end
  end

  a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted beat");

  a_issue_no_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.code_present) |-> (out_data.outcome == OUT_NONE))
    else $error("issue result carries an outcome");

  a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.code_present) |-> (out_data.code < CODE_LIMIT))
    else $error("issued code out of range");

  a_outcome_validates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.outcome != OUT_NONE)) |-> out_data.validated)
    else $error("validate outcome without validated flag");

  a_hit_key_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && hit) |-> (key_r[tidx] == in_r.client_ip))
    else $error("hit on an entry with another key");

endmodule
